// ===== hw/rtl/hlbc_pkg.sv =====
// ----------------------------------------------------------------------------
// hlbc_pkg
// Types, constants and helpers shared by the buffer cache tag directory.
// ----------------------------------------------------------------------------
package hlbc_pkg;

  localparam int BUCKETS = 7;
  localparam int WAYS    = 4;
  localparam int ENTRIES = BUCKETS * WAYS;

  localparam int MODE_W  = 2;
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int SLOT_W  = 5;
  localparam int CNT_W   = 8;
  localparam int STAT_W  = 2;
  localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_GET     = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_PIN     = 2'd2,
    MODE_UNPIN   = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_BUF    = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic [CNT_W-1:0] cnt;
    logic             vld;
    logic [WAY_W-1:0] rank;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  // bucket row after reset: the highest way is most recent
  function automatic row_t reset_row();
    row_t r;
    for (int w = 0; w < WAYS; w++) begin
      r[w]      = '0;
      r[w].rank = WAY_W'(WAYS - 1 - w);
    end
    return r;
  endfunction

  // block number mod 7: octal digits fold since 8 mod 7 is 1
  function automatic logic [BKT_W-1:0] bucket_of(input logic [BLK_W-1:0] blk);
    logic [6:0] sa;
    logic [6:0] sb;
    logic [6:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    sa = '0;
    sb = '0;
    for (int i = 0; i < 5; i++) begin
      sa = sa + 7'(blk[3*i +: 3]);
    end
    for (int i = 5; i < 10; i++) begin
      sb = sb + 7'(blk[3*i +: 3]);
    end
    s1 = sa + sb + 7'(blk[31:30]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]) + 4'(s1[6]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    if (s3 >= 4'(BUCKETS)) begin
      s3 = s3 - 4'(BUCKETS);
    end
    return BKT_W'(s3);
  endfunction

endpackage

// ===== hw/rtl/hlbc_if.sv =====
// ----------------------------------------------------------------------------
// hlbc_req_if / hlbc_rsp_if
// Valid/ready channels for requests and results of the tag directory.
// ----------------------------------------------------------------------------
interface hlbc_req_if;
  logic                          valid;
  logic                          ready;
  logic [hlbc_pkg::MODE_W-1:0]   mode;
  logic [hlbc_pkg::DEV_W-1:0]    device;
  logic [hlbc_pkg::BLK_W-1:0]    block_number;
  logic [hlbc_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, mode, device, block_number, slot, input ready);
  modport sink   (input valid, mode, device, block_number, slot, output ready);
endinterface

interface hlbc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hlbc_pkg::SLOT_W-1:0]   entry_index;
  logic                          hit;
  logic                          needs_read;
  logic [hlbc_pkg::CNT_W-1:0]    count_after;
  logic [hlbc_pkg::STAT_W-1:0]   status;

  modport source (output valid, entry_index, hit, needs_read, count_after, status,
                  input ready);
  modport sink   (input valid, entry_index, hit, needs_read, count_after, status,
                  output ready);
endinterface

// ===== hw/rtl/hashed_lru_buffer_cache_top.sv =====
// ----------------------------------------------------------------------------
// hashed_lru_buffer_cache_top
// Tag directory of a hashed, bucketed LRU block buffer cache.
// ----------------------------------------------------------------------------
// usage:
//   in_if  request channel: mode (get, release, pin, unpin), device,
//          block_number for get, slot for the other modes
//   out_if one result per request: entry_index, hit, needs_read,
//          count_after, status
// each bucket (block_number mod 7 for get, slot / 4 otherwise) is one row
// of a single-port memory that holds all ways; a request reads its row at
// the accepting edge, and the execute state computes the result and writes
// the row back when the result register can take it
// result: registered when the execute state commits, after the row read
// order: a new request is taken only after the previous one has written
//   its bucket row back, so the write completes before the next read is issued
// reset: per-row valid flops are cleared, so an unwritten row reads as its
//   reset contents; no clearing pass, requests are taken right away
// stall: the result register holds while out_if.ready is low; one further
//   request is accepted and waits in the execute cycle until it drains
// ----------------------------------------------------------------------------
module hashed_lru_buffer_cache_top (
  input  logic        clk,
  input  logic        rst_n,
  hlbc_req_if.sink    in_if,
  hlbc_rsp_if.source  out_if
);

  hlbc_pkg::row_t                  mem [hlbc_pkg::BUCKETS];
  logic [hlbc_pkg::BUCKETS-1:0]    row_vld_r;
  hlbc_pkg::row_t                  rd_row_r;
  logic                            rd_vld_r;

  hlbc_pkg::state_t                state_r, state_nxt;

  hlbc_pkg::mode_t                 mode_r;
  logic [hlbc_pkg::DEV_W-1:0]      dev_r;
  logic [hlbc_pkg::BLK_W-1:0]      blk_r;
  logic [hlbc_pkg::SLOT_W-1:0]     slot_r;
  logic [hlbc_pkg::BKT_W-1:0]      bkt_r;
  logic [hlbc_pkg::WAY_W-1:0]      way_r;
  logic                            oor_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [hlbc_pkg::SLOT_W-1:0]     out_idx_r;
  logic                            out_hit_r;
  logic                            out_nr_r;
  logic [hlbc_pkg::CNT_W-1:0]      out_cnt_r;
  hlbc_pkg::status_t               out_st_r;

  logic                            accept;
  logic                            commit;
  logic                            in_oor;
  logic [hlbc_pkg::BKT_W-1:0]      in_bkt;
  logic [hlbc_pkg::BKT_W-1:0]      rd_addr;

  hlbc_pkg::row_t                  row;
  hlbc_pkg::row_t                  new_row;
  logic                            wr_en;
  logic [hlbc_pkg::SLOT_W-1:0]     r_idx;
  logic                            r_hit;
  logic                            r_nr;
  logic [hlbc_pkg::CNT_W-1:0]      r_cnt;
  hlbc_pkg::status_t               r_st;

  // request decode
  assign in_oor = (in_if.slot >= hlbc_pkg::SLOT_W'(hlbc_pkg::ENTRIES));
  always_comb begin
    if (hlbc_pkg::mode_t'(in_if.mode) == hlbc_pkg::MODE_GET) begin
      in_bkt = hlbc_pkg::bucket_of(in_if.block_number);
    end else begin
      in_bkt = hlbc_pkg::BKT_W'(in_if.slot / hlbc_pkg::WAYS);
    end
  end
  assign rd_addr = (hlbc_pkg::mode_t'(in_if.mode) != hlbc_pkg::MODE_GET && in_oor)
                   ? '0 : in_bkt;

  assign accept = in_if.valid && in_if.ready;
  assign commit = (state_r == hlbc_pkg::S_EXEC) && (!out_valid_r || out_if.ready);

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hlbc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_if.ready = 1'b0;
    case (state_r)
      hlbc_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          state_nxt = hlbc_pkg::S_EXEC;
        end
      end
      hlbc_pkg::S_EXEC: begin
        if (commit) begin
          state_nxt = hlbc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = hlbc_pkg::S_IDLE;
      end
    endcase
  end

  // request registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= hlbc_pkg::mode_t'(in_if.mode);
      dev_r  <= in_if.device;
      blk_r  <= in_if.block_number;
      slot_r <= in_if.slot;
      bkt_r  <= rd_addr;
      way_r  <= hlbc_pkg::WAY_W'(in_if.slot % hlbc_pkg::WAYS);
      oor_r  <= in_oor;
    end
  end

  // bucket row memory
  always_ff @(posedge clk) begin
    if (commit && wr_en) begin
      mem[bkt_r] <= new_row;
    end
    if (accept) begin
      rd_row_r <= mem[rd_addr];
      rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (commit && wr_en) begin
      row_vld_r[bkt_r] <= 1'b1;
    end
  end

  // execute: search, update and result
  always_comb begin
    logic                        found;
    logic                        vfound;
    logic [hlbc_pkg::WAY_W-1:0]  best;
    logic [hlbc_pkg::WAY_W-1:0]  vic;
    logic [hlbc_pkg::WAY_W-1:0]  old_rank;
    logic [hlbc_pkg::CNT_W-1:0]  cnt;

    row      = rd_vld_r ? rd_row_r : hlbc_pkg::reset_row();
    new_row  = row;
    wr_en    = 1'b0;
    found    = 1'b0;
    vfound   = 1'b0;
    best     = '0;
    vic      = '0;
    old_rank = row[way_r].rank;
    cnt      = row[way_r].cnt;
    r_idx    = slot_r;
    r_hit    = 1'b0;
    r_nr     = 1'b0;
    r_cnt    = '0;
    r_st     = hlbc_pkg::ST_OK;

    for (int w = 0; w < hlbc_pkg::WAYS; w++) begin
      if (row[w].dev == dev_r && row[w].blk == blk_r &&
          (!found || row[w].rank < row[best].rank)) begin
        best  = hlbc_pkg::WAY_W'(w);
        found = 1'b1;
      end
    end
    for (int w = 0; w < hlbc_pkg::WAYS; w++) begin
      if (row[w].cnt == '0 && (!vfound || row[w].rank > row[vic].rank)) begin
        vic    = hlbc_pkg::WAY_W'(w);
        vfound = 1'b1;
      end
    end

    case (mode_r)
      hlbc_pkg::MODE_GET: begin
        if (found) begin
          r_idx = hlbc_pkg::SLOT_W'(bkt_r * hlbc_pkg::WAYS + best);
          r_hit = 1'b1;
          if (row[best].cnt == hlbc_pkg::CNT_MAX) begin
            r_cnt = row[best].cnt;
            r_st  = hlbc_pkg::ST_OVERFLOW;
          end else begin
            new_row[best].cnt = row[best].cnt + 1'b1;
            new_row[best].vld = 1'b1;
            wr_en = 1'b1;
            r_nr  = !row[best].vld;
            r_cnt = row[best].cnt + 1'b1;
          end
        end else if (vfound) begin
          new_row[vic].dev = dev_r;
          new_row[vic].blk = blk_r;
          new_row[vic].cnt = hlbc_pkg::CNT_W'(1);
          new_row[vic].vld = 1'b1;
          wr_en = 1'b1;
          r_idx = hlbc_pkg::SLOT_W'(bkt_r * hlbc_pkg::WAYS + vic);
          r_nr  = 1'b1;
          r_cnt = hlbc_pkg::CNT_W'(1);
        end else begin
          r_idx = '0;
          r_st  = hlbc_pkg::ST_NO_BUF;
        end
      end
      hlbc_pkg::MODE_PIN: begin
        if (!oor_r) begin
          if (cnt == hlbc_pkg::CNT_MAX) begin
            r_cnt = cnt;
            r_st  = hlbc_pkg::ST_OVERFLOW;
          end else begin
            new_row[way_r].cnt = cnt + 1'b1;
            wr_en = 1'b1;
            r_cnt = cnt + 1'b1;
          end
        end
      end
      hlbc_pkg::MODE_RELEASE, hlbc_pkg::MODE_UNPIN: begin
        if (!oor_r) begin
          if (cnt == '0) begin
            r_st = hlbc_pkg::ST_UNDERFLOW;
          end else begin
            new_row[way_r].cnt = cnt - 1'b1;
            wr_en = 1'b1;
            r_cnt = cnt - 1'b1;
            if (mode_r == hlbc_pkg::MODE_RELEASE && cnt == hlbc_pkg::CNT_W'(1)) begin
              for (int w = 0; w < hlbc_pkg::WAYS; w++) begin
                if (row[w].rank < old_rank) begin
                  new_row[w].rank = row[w].rank + 1'b1;
                end
              end
              new_row[way_r].rank = '0;
            end
          end
        end
      end
      default: begin
        r_st = hlbc_pkg::ST_OK;
      end
    endcase
  end

  // result register
  assign out_valid_nxt = (out_valid_r && !out_if.ready) || commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_idx_r <= r_idx;
      out_hit_r <= r_hit;
      out_nr_r  <= r_nr;
      out_cnt_r <= r_cnt;
      out_st_r  <= r_st;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.entry_index = out_idx_r;
  assign out_if.hit         = out_hit_r;
  assign out_if.needs_read  = out_nr_r;
  assign out_if.count_after = out_cnt_r;
  assign out_if.status      = out_st_r;

endmodule

// ===== hw/rtl/hlbc_checker.sv =====
// ----------------------------------------------------------------------------
// hlbc_checker
// Port-level checks of the tag directory, bound to the top level.
// ----------------------------------------------------------------------------
module hlbc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [hlbc_pkg::SLOT_W-1:0]   out_entry_index,
  input logic                          out_hit,
  input logic                          out_needs_read,
  input logic [hlbc_pkg::CNT_W-1:0]    out_count_after,
  input logic [hlbc_pkg::STAT_W-1:0]   out_status
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the row is busy in the cycle after a transaction is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken during read-modify-write");

  // no free buffer reports an empty grant
  a_no_buf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == hlbc_pkg::ST_NO_BUF |->
      out_entry_index == '0 && !out_hit && !out_needs_read && out_count_after == '0)
    else $error("no-buffer result carries a grant");

  // a granted reference always leaves a nonzero count
  a_grant_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_needs_read |->
      out_status == hlbc_pkg::ST_OK && out_count_after != '0)
    else $error("needs_read without a valid grant");

endmodule

bind hashed_lru_buffer_cache_top hlbc_checker u_hlbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_entry_index (out_if.entry_index),
  .out_hit         (out_if.hit),
  .out_needs_read  (out_if.needs_read),
  .out_count_after (out_if.count_after),
  .out_status      (out_if.status)
);
